// ----- sv/pav_pkg.sv -----
// ----------------------------------------------------------------------------
// pav_pkg
// shared types and constants of the pps apdo capability validator
// ----------------------------------------------------------------------------
package pav_pkg;

    localparam int VOL_W  = 15;
    localparam int CUR_W  = 13;
    localparam int MODE_W = 3;
    localparam int QUOT_W = 14;
    localparam int PWR_W  = 25;

    localparam logic [PWR_W-1:0]  POWER_LIMIT_UW = 25'd30000000;
    localparam logic [QUOT_W-1:0] CUR_RESERVE_MA = 14'd400;
    localparam logic [6:0]        CUR_STEP_MA    = 7'd100;
    // floor(x / 100) = (x * 41944) >> 22 for x below 2^14
    localparam logic [15:0]       STEP_RECIP     = 16'd41944;
    localparam int                STEP_SHIFT     = 22;

    localparam logic [VOL_W-1:0] GREY_VOL_MV   = 15'd10000;
    localparam logic [CUR_W-1:0] GREY_CUR_MA   = 13'd2000;
    localparam logic [VOL_W-1:0] VOL_LIMIT_SC4 = 15'd30000;
    localparam logic [VOL_W-1:0] VOL_LIMIT_SC2 = 15'd15000;
    localparam logic [VOL_W-1:0] VOL_FLOOR_MV  = 15'd3000;
    localparam logic [VOL_W-1:0] LVC_MAX_MV    = 15'd5500;
    localparam logic [VOL_W-1:0] LVC_MIN_MV    = 15'd3400;
    localparam logic [VOL_W-1:0] SC_MAX_MV     = 15'd11000;
    localparam logic [VOL_W-1:0] SC_MIN_MV     = 15'd5500;
    localparam logic [VOL_W-1:0] SC4_MAX_MV    = 15'd21000;
    localparam logic [VOL_W-1:0] SC4_MIN_MV    = 15'd11000;

    localparam logic REG_SC4_SUPPORTED = 1'b0;
    localparam logic REG_GREY_LIMIT    = 1'b1;

    typedef struct packed {
        logic             start;
        logic [VOL_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

endpackage

// ----- sv/pav_div.sv -----
// ----------------------------------------------------------------------------
// pav_div
// restoring divider, one quotient bit per cycle, fixed 30 W dividend
// ----------------------------------------------------------------------------
module pav_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  pav_pkg::div_req_t req,
    output pav_pkg::div_rsp_t rsp
);

    localparam int CNT_W = $clog2(pav_pkg::QUOT_W);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [pav_pkg::VOL_W-1:0]   rem_reg, rem_next;
    logic [pav_pkg::QUOT_W-1:0]  quot_reg, quot_next;
    logic [pav_pkg::VOL_W-1:0]   div_reg, div_next;
    logic [pav_pkg::VOL_W:0]     shifted;
    logic [pav_pkg::VOL_W:0]     diff;

    assign shifted = {rem_reg, quot_reg[pav_pkg::QUOT_W-1]};
    assign diff    = shifted - {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        div_next  = div_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            div_next  = req.divisor;
            // upper dividend bits already sit below any divisor of 3000 or more
            rem_next  = pav_pkg::VOL_W'(pav_pkg::POWER_LIMIT_UW[pav_pkg::PWR_W-1:pav_pkg::QUOT_W]);
            quot_next = pav_pkg::POWER_LIMIT_UW[pav_pkg::QUOT_W-1:0];
        end else if (busy_reg) begin
            if (shifted >= {1'b0, div_reg}) begin
                rem_next  = diff[pav_pkg::VOL_W-1:0];
                quot_next = {quot_reg[pav_pkg::QUOT_W-2:0], 1'b1};
            end else begin
                rem_next  = shifted[pav_pkg::VOL_W-1:0];
                quot_next = {quot_reg[pav_pkg::QUOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(pav_pkg::QUOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                cnt_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        div_reg  <= div_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg)
        else $error("divider not busy after start");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && cnt_reg == '0)
        else $error("divider done while still iterating");

endmodule

// ----- sv/pps_apdo_cap_validator.sv -----
// ----------------------------------------------------------------------------
// pps_apdo_cap_validator
// checks and clamps one pps apdo capability per transfer, keeps set aggregates
// ----------------------------------------------------------------------------
//  channel   dir   ports                          payload
//  s_        in    s_tvalid s_tready s_tdata      vol_min, vol_max, cur
//                  s_tuser                        first_of_set
//  m_        out   m_tvalid m_tready m_tdata      outputs and set aggregates
//                  m_tuser                        cap_ok
//  cfg_      in    cfg_wr_en cfg_addr cfg_wr_data sc4_supported, grey_limit
//
//  invalid capabilities and sc4 support get no power cap; otherwise the current is
//  capped via the 14-step restoring divider. synchronous active-low reset clears
//  the sequencer, aggregates, output valid and grey_limit, and sets sc4_supported.
//  one capability at a time; the next is taken while a result waits in the output
//  register, and a stalled m_ side holds the sequencer before update.
// ----------------------------------------------------------------------------
module pps_apdo_cap_validator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // cap_vol_min, cap_vol_max, cap_cur_ma, zero fill
    input  logic [0:0]  s_tuser,   // first_of_set
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // out_vol_min, out_vol_max, out_cur, cap_modes,
                                   // set_vol_max, set_vol_min, set_cur_max,
                                   // set_modes, zero fill
    output logic [0:0]  m_tuser,   // cap_ok
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic        cfg_wr_data
);

    localparam int VW = pav_pkg::VOL_W;
    localparam int CW = pav_pkg::CUR_W;
    localparam int MW = pav_pkg::MODE_W;
    localparam int QW = pav_pkg::QUOT_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_CAP1  = 6'b001000,
        ST_CAP2  = 6'b010000,
        ST_AGG   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic          sc4_reg, grey_reg;
    logic [VW-1:0] vmin_reg, vmax_reg, limit_reg;
    logic [CW-1:0] cur_reg;
    logic          ok_reg;
    logic          first_reg;
    logic [6:0]    steps_reg;

    logic [VW-1:0] agg_vmax_reg, agg_vmin_reg;
    logic [CW-1:0] agg_cur_reg;
    logic [MW-1:0] agg_modes_reg;
    logic [VW-1:0] agg_vmax_next, agg_vmin_next;
    logic [CW-1:0] agg_cur_next;
    logic [MW-1:0] agg_modes_next;

    logic          mvalid_reg;
    logic [95:0]   mdata_reg;
    logic          mok_reg;

    logic [VW-1:0] in_vmin, in_vmax, vmax_clamp, cap;
    logic [CW-1:0] in_cur;
    logic          ok_comb, accept, out_free;
    logic [QW-1:0] tsum;
    logic [29:0]   prod;
    logic [MW-1:0] modes;

    pav_pkg::div_req_t div_req;
    pav_pkg::div_rsp_t div_rsp;

    pav_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign in_vmin  = s_tdata[14:0];
    assign in_vmax  = s_tdata[29:15];
    assign in_cur   = s_tdata[42:30];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;

    assign ok_comb = (cur_reg != '0) && (vmax_reg != '0) && (vmin_reg != '0)
                  && (vmax_reg >= pav_pkg::VOL_FLOOR_MV) && (vmax_reg >= vmin_reg)
                  && (vmin_reg < limit_reg);
    assign vmax_clamp = (vmax_reg > limit_reg) ? limit_reg : vmax_reg;

    assign div_req.start   = (state_reg == ST_CHECK) && ok_comb && !sc4_reg;
    assign div_req.divisor = vmax_clamp;

    assign tsum = div_rsp.quot + pav_pkg::CUR_RESERVE_MA;
    assign prod = tsum * pav_pkg::STEP_RECIP;
    assign cap  = VW'(steps_reg * pav_pkg::CUR_STEP_MA);

    always_comb begin
        modes = '0;
        if (vmax_reg >= pav_pkg::LVC_MAX_MV && vmin_reg <= pav_pkg::LVC_MIN_MV) begin
            modes[0] = 1'b1;
        end
        if (vmax_reg >= pav_pkg::SC_MAX_MV && vmin_reg <= pav_pkg::SC_MIN_MV) begin
            modes[1] = 1'b1;
        end
        if (sc4_reg && vmax_reg >= pav_pkg::SC4_MAX_MV && vmin_reg <= pav_pkg::SC4_MIN_MV) begin
            modes[2] = 1'b1;
        end
        if (!ok_reg) begin
            modes = '0;
        end
    end

    // a new set starts from zero, then the valid capability is folded in
    always_comb begin
        agg_vmax_next  = first_reg ? '0 : agg_vmax_reg;
        agg_vmin_next  = first_reg ? '0 : agg_vmin_reg;
        agg_cur_next   = first_reg ? '0 : agg_cur_reg;
        agg_modes_next = first_reg ? '0 : agg_modes_reg;
        if (ok_reg) begin
            if (vmax_reg > agg_vmax_next) begin
                agg_vmax_next = vmax_reg;
            end
            if (agg_vmin_next == '0 || vmin_reg < agg_vmin_next) begin
                agg_vmin_next = vmin_reg;
            end
            if (cur_reg > agg_cur_next) begin
                agg_cur_next = cur_reg;
            end
            agg_modes_next = agg_modes_next | modes;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = div_req.start ? ST_DIV : ST_AGG;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_CAP1;
                end
            end
            ST_CAP1: state_next = ST_CAP2;
            ST_CAP2: state_next = ST_AGG;
            ST_AGG: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sc4_reg       <= 1'b1;
            grey_reg      <= 1'b0;
            agg_vmax_reg  <= '0;
            agg_vmin_reg  <= '0;
            agg_cur_reg   <= '0;
            agg_modes_reg <= '0;
            mvalid_reg    <= 1'b0;
            ok_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    pav_pkg::REG_SC4_SUPPORTED: sc4_reg  <= cfg_wr_data;
                    pav_pkg::REG_GREY_LIMIT:    grey_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_CHECK) begin
                ok_reg <= ok_comb;
            end
            if (state_reg == ST_AGG && out_free) begin
                mvalid_reg    <= 1'b1;
                agg_vmax_reg  <= agg_vmax_next;
                agg_vmin_reg  <= agg_vmin_next;
                agg_cur_reg   <= agg_cur_next;
                agg_modes_reg <= agg_modes_next;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end

        if (accept) begin
            first_reg <= s_tuser[0];
            vmin_reg  <= in_vmin;
            vmax_reg  <= in_vmax;
            cur_reg   <= (grey_reg && in_cur > pav_pkg::GREY_CUR_MA) ? pav_pkg::GREY_CUR_MA
                                                                       : in_cur;
            if (grey_reg) begin
                limit_reg <= pav_pkg::GREY_VOL_MV;
            end else begin
                limit_reg <= sc4_reg ? pav_pkg::VOL_LIMIT_SC4 : pav_pkg::VOL_LIMIT_SC2;
            end
        end
        if (state_reg == ST_CHECK) begin
            vmax_reg <= vmax_clamp;
        end
        if (state_reg == ST_CAP1) begin
            steps_reg <= prod[pav_pkg::STEP_SHIFT+6:pav_pkg::STEP_SHIFT];
        end
        if (state_reg == ST_CAP2 && {2'b00, cur_reg} > cap) begin
            cur_reg <= cap[CW-1:0];
        end
        if (state_reg == ST_AGG && out_free) begin
            mok_reg <= ok_reg;
            mdata_reg[14:0]  <= ok_reg ? vmin_reg : '0;
            mdata_reg[29:15] <= ok_reg ? vmax_reg : '0;
            mdata_reg[42:30] <= ok_reg ? cur_reg : '0;
            mdata_reg[45:43] <= modes;
            mdata_reg[91:46] <= {agg_modes_next, agg_cur_next, agg_vmin_next, agg_vmax_next};
            mdata_reg[95:92] <= '0;
        end
    end

    // aggregates go out as they stand after the update
    assign m_tvalid   = mvalid_reg;
    assign m_tuser[0] = mok_reg;
    assign m_tdata    = mdata_reg;

    a_agg_order: assert property (@(posedge aclk) disable iff (!aresetn)
        agg_vmax_reg >= agg_vmin_reg)
        else $error("set maximum voltage below set minimum");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.busy || div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider running outside its state");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mvalid_reg) && !mok_reg |-> mdata_reg[45:0] == '0)
        else $error("invalid capability not zeroed");

endmodule
